### rtl/core/ppfc_pkg.sv
// Shared widths, register indexes and divider types for the projection core.
`timescale 1ns / 1ps
package ppfc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int IDX_W     = 16;
    localparam int PIX_W     = 28;
    localparam int DEPTH_W   = 31;
    localparam int DIM_W     = 12;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W    = 2 * COORD_W;
    // three shifted products plus translation, with headroom
    localparam int XW        = PROD_W - FRAC_BITS + 3;
    localparam int LIM_W     = DIM_W + DEPTH_W;
    localparam int D_W       = LIM_W + 1;
    localparam int QW        = DIM_W + FRAC_BITS;
    localparam int NW        = D_W + FRAC_BITS - 1;
    localparam int REM_W     = NW - QW;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_B = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(7);

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

    // one lane of the restoring divider
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    nlo;
        logic [QW-1:0]    quo;
    } t_div_lane;

endpackage

### rtl/core/point_projection_fov_cull_core.sv
// Pinhole projection with view culling: transform, bounds test, pipelined divide.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+----------------------------------------
//  in      | in  | i_in_valid / o_in_stall    | i_point_x/y/z (Q16.16), i_point_index
//  out     | out | o_out_valid / i_out_stall  | o_kept_index, o_pixel_u/v, o_depth
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data (64 bit)
//
// One word (a Q16.16 point) accepted per clock while o_in_stall is low. The pipe holds one
// stage of nine 32x32 multipliers, a summing stage, a depth check and bound
// multiply stage, a bound test stage, then one quotient bit per stage for u and v
// in parallel restoring dividers. Reset (synchronous, active low) clears all valid
// bits and loads the default registers. The whole pipe moves together; a two-deep
// output (register plus skid) lets it run while a result waits, and the input
// stall is simply the skid being occupied. Culled points leave no word.
`timescale 1ns / 1ps
module point_projection_fov_cull_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [ppfc_pkg::COORD_W-1:0]     i_point_x,
    input  logic signed [ppfc_pkg::COORD_W-1:0]     i_point_y,
    input  logic signed [ppfc_pkg::COORD_W-1:0]     i_point_z,
    input  logic        [ppfc_pkg::IDX_W-1:0]       i_point_index,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic        [ppfc_pkg::IDX_W-1:0]       o_kept_index,
    output logic        [ppfc_pkg::PIX_W-1:0]       o_pixel_u,
    output logic        [ppfc_pkg::PIX_W-1:0]       o_pixel_v,
    output logic        [ppfc_pkg::DEPTH_W-1:0]     o_depth,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [ppfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [ppfc_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int F   = ppfc_pkg::FRAC_BITS;
    localparam int XW  = ppfc_pkg::XW;
    localparam int QW  = ppfc_pkg::QW;
    localparam int LW  = ppfc_pkg::LIM_W;
    localparam int DW  = ppfc_pkg::D_W;
    localparam int NW  = ppfc_pkg::NW;
    localparam int RW  = ppfc_pkg::REM_W;
    localparam int ZW  = ppfc_pkg::DEPTH_W;
    localparam int IW  = ppfc_pkg::IDX_W;
    localparam int PW  = ppfc_pkg::PROD_W;

    // ---------------- configuration registers ----------------
    logic [ppfc_pkg::CFG_W-1:0] r_coef [0:5];
    logic [ppfc_pkg::DIM_W-1:0] r_width;
    logic [ppfc_pkg::DIM_W-1:0] r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_coef[k] <= '0;
            r_width  <= ppfc_pkg::WIDTH_RST;
            r_height <= ppfc_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppfc_pkg::CFG_ROW0_A: r_coef[0] <= i_cfg_data;
                ppfc_pkg::CFG_ROW0_B: r_coef[1] <= i_cfg_data;
                ppfc_pkg::CFG_ROW1_A: r_coef[2] <= i_cfg_data;
                ppfc_pkg::CFG_ROW1_B: r_coef[3] <= i_cfg_data;
                ppfc_pkg::CFG_ROW2_A: r_coef[4] <= i_cfg_data;
                ppfc_pkg::CFG_ROW2_B: r_coef[5] <= i_cfg_data;
                ppfc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[ppfc_pkg::DIM_W-1:0];
                ppfc_pkg::CFG_HEIGHT: r_height <= i_cfg_data[ppfc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_skid_valid;
    logic en;
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // ---------------- stage 1: products ----------------
    // r1_p[3*row + col]: col 0..2 multiply x, y, z
    logic                 r1_v;
    logic [IW-1:0]        r1_idx;
    logic signed [PW-1:0] r1_p [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_idx <= i_point_index;
            for (int r = 0; r < 3; r++) begin
                r1_p[3*r]   <= $signed(r_coef[2*r][31:0])    * i_point_x;
                r1_p[3*r+1] <= $signed(r_coef[2*r][63:32])   * i_point_y;
                r1_p[3*r+2] <= $signed(r_coef[2*r+1][31:0])  * i_point_z;
            end
        end
    end

    // ---------------- stage 2: floor shift and row sums ----------------
    logic                 r2_v;
    logic [IW-1:0]        r2_idx;
    logic signed [XW-1:0] r2_xyz [0:2];
    logic signed [PW-1:0] sh [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) sh[k] = r1_p[k] >>> F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_idx <= r1_idx;
            for (int r = 0; r < 3; r++) begin
                r2_xyz[r] <= XW'(sh[3*r]) + XW'(sh[3*r+1]) + XW'(sh[3*r+2])
                           + XW'($signed(r_coef[2*r+1][63:32]));
            end
        end
    end

    // ---------------- stage 3: depth check, bound products ----------------
    logic                 r3_v;
    logic [IW-1:0]        r3_idx;
    logic signed [XW-1:0] r3_x;
    logic signed [XW-1:0] r3_y;
    logic [ZW-1:0]        r3_z;
    logic [LW-1:0]        r3_limx;
    logic [LW-1:0]        r3_limy;
    logic                 z_ok;

    // 0 < Z <= 2^31-1
    assign z_ok = (r2_xyz[2][XW-1:ZW] == '0) && (r2_xyz[2][ZW-1:0] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v && z_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_idx  <= r2_idx;
            r3_x    <= r2_xyz[0];
            r3_y    <= r2_xyz[1];
            r3_z    <= r2_xyz[2][ZW-1:0];
            r3_limx <= LW'(r_width)  * LW'(r2_xyz[2][ZW-1:0]);
            r3_limy <= LW'(r_height) * LW'(r2_xyz[2][ZW-1:0]);
        end
    end

    // ---------------- stage 4: bound test, divider load ----------------
    // -lim <= 2n < lim; dividend is (2n + lim) << (F-1), quotient is u directly
    localparam int TW = XW + 2;
    logic signed [TW-1:0] tx2;
    logic signed [TW-1:0] ty2;
    logic signed [TW-1:0] slx;
    logic signed [TW-1:0] sly;
    logic signed [TW-1:0] sumx;
    logic signed [TW-1:0] sumy;
    logic                 in_x;
    logic                 in_y;
    logic [NW-1:0]        nx;
    logic [NW-1:0]        ny;

    always_comb begin
        tx2  = TW'(r3_x) <<< 1;
        ty2  = TW'(r3_y) <<< 1;
        slx  = $signed(TW'(r3_limx));
        sly  = $signed(TW'(r3_limy));
        in_x = (tx2 >= -slx) && (tx2 < slx);
        in_y = (ty2 >= -sly) && (ty2 < sly);
        sumx = tx2 + slx;
        sumy = ty2 + sly;
        nx   = NW'(sumx[DW-1:0]) << (F - 1);
        ny   = NW'(sumy[DW-1:0]) << (F - 1);
    end

    // divider pipe: index 0 is the loaded word, index QW holds finished quotients
    logic                    r_dv   [0:QW];
    logic [IW-1:0]           r_didx [0:QW];
    logic [ZW-1:0]           r_dz   [0:QW];
    ppfc_pkg::t_div_lane     r_du   [0:QW];
    ppfc_pkg::t_div_lane     r_dvv  [0:QW];

    function automatic ppfc_pkg::t_div_lane div_step(input ppfc_pkg::t_div_lane a,
                                                      input logic [ZW-1:0] d);
        ppfc_pkg::t_div_lane b;
        logic [RW:0]         t;
        logic                ge;
        t     = {a.rem, a.nlo[QW-1]};
        ge    = (t >= (RW+1)'(d));
        b.rem = ge ? RW'(t - (RW+1)'(d)) : RW'(t);
        b.nlo = a.nlo << 1;
        b.quo = {a.quo[QW-2:0], ge};
        return b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r3_v && in_x && in_y;
            for (int k = 1; k <= QW; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_didx[0]    <= r3_idx;
            r_dz[0]      <= r3_z;
            r_du[0].rem  <= nx[NW-1:QW];
            r_du[0].nlo  <= nx[QW-1:0];
            r_du[0].quo  <= '0;
            r_dvv[0].rem <= ny[NW-1:QW];
            r_dvv[0].nlo <= ny[QW-1:0];
            r_dvv[0].quo <= '0;
            for (int k = 1; k <= QW; k++) begin
                r_didx[k] <= r_didx[k-1];
                r_dz[k]   <= r_dz[k-1];
                r_du[k]   <= div_step(r_du[k-1],  r_dz[k-1]);
                r_dvv[k]  <= div_step(r_dvv[k-1], r_dz[k-1]);
            end
        end
    end

    // ---------------- output register and skid ----------------
    logic          last_v;
    logic          take;
    logic          r_out_valid;
    logic [IW-1:0] r_o_idx, r_s_idx;
    logic [ppfc_pkg::PIX_W-1:0] r_o_u, r_o_v, r_s_u, r_s_v;
    logic [ZW-1:0] r_o_z, r_s_z;

    assign last_v = en && r_dv[QW];
    assign take   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= last_v;
            end
        end else if (last_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_o_idx <= r_s_idx;
                r_o_u   <= r_s_u;
                r_o_v   <= r_s_v;
                r_o_z   <= r_s_z;
            end else begin
                r_o_idx <= r_didx[QW];
                r_o_u   <= ppfc_pkg::PIX_W'(r_du[QW].quo);
                r_o_v   <= ppfc_pkg::PIX_W'(r_dvv[QW].quo);
                r_o_z   <= r_dz[QW];
            end
        end else if (last_v) begin
            r_s_idx <= r_didx[QW];
            r_s_u   <= ppfc_pkg::PIX_W'(r_du[QW].quo);
            r_s_v   <= ppfc_pkg::PIX_W'(r_dvv[QW].quo);
            r_s_z   <= r_dz[QW];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kept_index = r_o_idx;
    assign o_pixel_u    = r_o_u;
    assign o_pixel_v    = r_o_v;
    assign o_depth      = r_o_z;

endmodule
